### rtl/elevator_group_scan_dispatch_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elevator group dispatcher
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_GROUP_SCAN_DISPATCH_TOP_ASSERT_SVH
`define ELEVATOR_GROUP_SCAN_DISPATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define EGSD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next.
`define EGSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define EGSD_ASSERT(name, clk, rst_n, prop, msg)
`define EGSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg
// Shared constants, types and helpers of the elevator group dispatcher.
// ----------------------------------------------------------------------------
package egsd_pkg;

	localparam int NUM_CARS_DEF   = 3;
	localparam int NUM_FLOORS_DEF = 64;

	localparam int CAR_W   = 3;
	localparam int FLOOR_W = 6;
	localparam int HEAD_W  = 2;

	localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd0;
	localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd1;
	localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd2;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Control of the car state memory; reads and writes share one address.
	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [CAR_W-1:0] addr;
	} mem_ctl_t;

	// Index of the lowest set bit of an eight bit slice (zero if none).
	function automatic logic [2:0] lowest8(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/elevator_group_scan_dispatch_top.sv
// ----------------------------------------------------------------------------
// elevator_group_scan_dispatch_top
// Elevator group dispatcher: nearest-car hall assignment and SCAN service.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                        | Contents
//  ---------+-----------+--------------------------------+-------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser | hall request or tick command
//  m_*      | out       | m_tvalid m_tready m_tdata m_tlast | assignment or per-car report
//
//  A hall request is accepted, then each car is read and evaluated in turn,
//  and the chosen car, if any, is written back with the assignment beat. A
//  tick is accepted, then each car is read, evaluated and encoded, and written
//  back with its report beat. Reads and writes go through the single shared
//  port of the car state memory.
//  Reset clears control state and the memory valid bits at once; no clearing
//  pass is needed. A stalled output holds the sequencer in its write-back
//  cycle, while a finished beat waiting on m_tready does not stop a new accept.
//
// ----------------------------------------------------------------------------
`include "elevator_group_scan_dispatch_top_assert.svh"

module elevator_group_scan_dispatch_top
	import egsd_pkg::*;
#(
	parameter int NUM_CARS   = NUM_CARS_DEF,
	parameter int NUM_FLOORS = NUM_FLOORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // floor[5:0], direction[7:6]
	input  logic        s_tuser,   // command: 0 hall request, 1 tick

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // car[2:0], car_floor[8:3], heading[10:9],
	                               // arrived[11], assigned[12], zero[15:13]
	output logic        m_tlast    // last beat caused by one input beat
);

	localparam int CAR_AW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
	localparam int NG     = (NUM_FLOORS + 7) / 8;
	localparam int PAD_W  = NG * 8;
	localparam int REC_W  = NUM_FLOORS + FLOOR_W + HEAD_W;

	localparam logic [CAR_AW-1:0] LAST_CAR = CAR_AW'(NUM_CARS - 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EV   = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_REQW = 3'd4;

	logic [2:0] state_q;
	logic [CAR_AW-1:0] idx_q;

	// Accepted command.
	logic               cmd_q;
	logic [FLOOR_W-1:0] floor_q;
	logic [HEAD_W-1:0]  dir_q;

	// Request search: best car so far and its record.
	logic                  found_q;
	logic [CAR_AW-1:0]     best_q;
	logic [FLOOR_W-1:0]    best_d_q;
	logic [NUM_FLOORS-1:0] best_pend_q;
	logic [FLOOR_W-1:0]    best_pos_q;
	logic [HEAD_W-1:0]     best_head_q;

	// Tick evaluation stage.
	logic [NUM_FLOORS-1:0] pend_s1;
	logic [FLOOR_W-1:0]    pos_s1;
	logic [HEAD_W-1:0]     head_s1;
	logic                  moved_s1;
	logic                  up_s1;
	logic [NG-1:0]         gnz_s1;
	logic [2:0]            gidx_s1 [NG];

	// Output register.
	logic               out_valid_q;
	logic [CAR_W-1:0]   out_car_q;
	logic [FLOOR_W-1:0] out_floor_q;
	logic [HEAD_W-1:0]  out_head_q;
	logic               out_arr_q;
	logic               out_asg_q;
	logic               out_last_q;

	mem_ctl_t         mem_ctl;
	logic [REC_W-1:0] mem_wdata;
	logic [REC_W-1:0] mem_rdata;

	egsd_car_mem #(
		.NUM_CARS (NUM_CARS),
		.REC_W    (REC_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	// ------------------------------------------------------------------
	// Fields of the record read back from memory.
	// ------------------------------------------------------------------
	logic [NUM_FLOORS-1:0] rd_pend;
	logic [FLOOR_W-1:0]    rd_pos;
	logic [HEAD_W-1:0]     rd_head;

	assign rd_pend = mem_rdata[REC_W-1 -: NUM_FLOORS];
	assign rd_pos  = mem_rdata[HEAD_W +: FLOOR_W];
	assign rd_head = mem_rdata[HEAD_W-1:0];

	// ------------------------------------------------------------------
	// Request evaluation: qualification and distance for the car just read.
	// ------------------------------------------------------------------
	logic               floor_ok;
	logic               qual;
	logic [FLOOR_W-1:0] span;
	logic               better;

	assign floor_ok = {1'b0, floor_q} < (FLOOR_W + 1)'(NUM_FLOORS);
	assign qual     = floor_ok && (rd_head == HEAD_IDLE || rd_head == dir_q);
	assign span     = (rd_pos > floor_q) ? (rd_pos - floor_q) : (floor_q - rd_pos);
	assign better   = qual && (!found_q || span < best_d_q);

	// ------------------------------------------------------------------
	// Tick evaluation: SCAN heading and candidate floors, then the first
	// level of the priority encoder (one lowest-bit search per byte).
	// A downward search runs on the bit-reversed candidates.
	// ------------------------------------------------------------------
	logic [NUM_FLOORS-1:0] up_m;
	logic [NUM_FLOORS-1:0] dn_m;
	logic [NUM_FLOORS-1:0] sel;
	logic [NUM_FLOORS-1:0] sel_o;
	logic [PAD_W-1:0]      sel_pad;
	logic                  empty;
	logic                  eff_up;
	logic                  moved;
	logic [HEAD_W-1:0]     new_head;
	logic [NG-1:0]         gnz;
	logic [2:0]            gidx [NG];

	always_comb begin
		up_m   = {NUM_FLOORS{1'b1}} << rd_pos;
		dn_m   = ~(({NUM_FLOORS{1'b1}} << rd_pos) << 1);
		empty  = (rd_pend == '0);
		// An idle car heads up only when nothing is pending at or below it.
		if (rd_head == HEAD_IDLE) begin
			eff_up = ((rd_pend & dn_m) == '0);
		end else begin
			eff_up = (rd_head == HEAD_UP);
		end
		sel   = eff_up ? (rd_pend & up_m) : (rd_pend & dn_m);
		moved = !empty && (sel != '0);
		if (empty) begin
			new_head = HEAD_IDLE;
		end else if (sel == '0) begin
			new_head = eff_up ? HEAD_DOWN : HEAD_UP;
		end else begin
			new_head = eff_up ? HEAD_UP : HEAD_DOWN;
		end
		for (int i = 0; i < NUM_FLOORS; i++) begin
			sel_o[i] = eff_up ? sel[i] : sel[NUM_FLOORS-1-i];
		end
		sel_pad = PAD_W'(sel_o);
		for (int g = 0; g < NG; g++) begin
			gnz[g]  = |sel_pad[g*8 +: 8];
			gidx[g] = lowest8(sel_pad[g*8 +: 8]);
		end
	end

	// ------------------------------------------------------------------
	// Tick write-back: second encoder level picks the lowest active byte.
	// ------------------------------------------------------------------
	logic [FLOOR_W-1:0]    lo_bit;
	logic [FLOOR_W-1:0]    target;
	logic [NUM_FLOORS-1:0] wr_pend;
	logic [FLOOR_W-1:0]    wr_pos;

	always_comb begin
		lo_bit = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (gnz_s1[g]) begin
				lo_bit = FLOOR_W'(g * 8) + FLOOR_W'(gidx_s1[g]);
			end
		end
		target  = up_s1 ? lo_bit : (FLOOR_W'(NUM_FLOORS - 1) - lo_bit);
		wr_pend = moved_s1 ? (pend_s1 & ~(NUM_FLOORS'(1) << target)) : pend_s1;
		wr_pos  = moved_s1 ? target : pos_s1;
	end

	// ------------------------------------------------------------------
	// Memory control and write data.
	// ------------------------------------------------------------------
	logic out_free;
	logic out_load;
	logic out_last_d;

	assign out_free   = !out_valid_q || m_tready;
	assign out_load   = out_free && (state_q == ST_WR || state_q == ST_REQW);
	assign out_last_d = (state_q == ST_REQW) || (idx_q == LAST_CAR);

	always_comb begin
		mem_ctl.rd_en = (state_q == ST_RD);
		mem_ctl.wr_en = out_free &&
			((state_q == ST_WR) || (state_q == ST_REQW && found_q));
		mem_ctl.addr  = (state_q == ST_REQW) ? CAR_W'(best_q) : CAR_W'(idx_q);
		if (state_q == ST_REQW) begin
			mem_wdata = {best_pend_q | (NUM_FLOORS'(1) << floor_q), best_pos_q, best_head_q};
		end else begin
			mem_wdata = {wr_pend, wr_pos, head_s1};
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (cmd_q == CMD_TICK) begin
						state_q <= ST_WR;
					end else begin
						if (better) begin
							found_q <= 1'b1;
						end
						if (idx_q == LAST_CAR) begin
							state_q <= ST_REQW;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_WR: begin
					if (out_free) begin
						if (idx_q == LAST_CAR) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_REQW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command capture, search bookkeeping and tick stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser;
			floor_q <= s_tdata[FLOOR_W-1:0];
			dir_q   <= s_tdata[FLOOR_W +: HEAD_W];
		end
		if (state_q == ST_EV) begin
			if (cmd_q == CMD_REQUEST && better) begin
				best_q      <= idx_q;
				best_d_q    <= span;
				best_pend_q <= rd_pend;
				best_pos_q  <= rd_pos;
				best_head_q <= rd_head;
			end
			pend_s1  <= rd_pend;
			pos_s1   <= rd_pos;
			head_s1  <= new_head;
			moved_s1 <= moved;
			up_s1    <= eff_up;
			gnz_s1   <= gnz;
			gidx_s1  <= gidx;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_last_q <= out_last_d;
			if (state_q == ST_REQW) begin
				out_car_q   <= found_q ? CAR_W'(best_q) : '0;
				out_floor_q <= floor_q;
				out_head_q  <= HEAD_UP;
				out_arr_q   <= 1'b0;
				out_asg_q   <= found_q;
			end else begin
				out_car_q   <= CAR_W'(idx_q);
				out_floor_q <= wr_pos;
				out_head_q  <= head_s1;
				out_arr_q   <= moved_s1;
				out_asg_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_asg_q, out_arr_q, out_head_q, out_floor_q, out_car_q};

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`EGSD_ASSERT(a_no_rw_clash, clk, arst_n, !(mem_ctl.rd_en && mem_ctl.wr_en), "memory read and write in one cycle")
	`EGSD_ASSERT_NEXT(a_accept_reads, clk, arst_n, s_tvalid && s_tready, state_q == ST_RD, "accepted beat did not start a read")
	`EGSD_ASSERT_NEXT(a_last_ends_item, clk, arst_n, out_load && out_last_d, state_q == ST_IDLE, "last beat loaded but sequencer still busy")
	`EGSD_ASSERT(a_arrival_heading, clk, arst_n, !(out_valid_q && out_arr_q) || out_head_q != HEAD_IDLE, "car arrived but reports idle heading")

endmodule

### rtl/egsd_car_mem.sv
// ----------------------------------------------------------------------------
// egsd_car_mem
// Per-car state memory with a registered read and reset valid bits.
// ----------------------------------------------------------------------------
module egsd_car_mem
	import egsd_pkg::*;
#(
	parameter int NUM_CARS = NUM_CARS_DEF,
	parameter int REC_W    = NUM_FLOORS_DEF + FLOOR_W + HEAD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_ctl_t         ctl,
	input  logic [REC_W-1:0] wdata,
	output logic [REC_W-1:0] rdata
);

	localparam int CAR_AW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

	// An entry never written since reset reads as an idle, empty car at floor zero.
	localparam logic [REC_W-1:0] RESET_REC = REC_W'(HEAD_IDLE);

	logic [REC_W-1:0]    mem_q [NUM_CARS];
	logic [NUM_CARS-1:0] valid_q;
	logic [REC_W-1:0]    raw_q;
	logic                rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.addr[CAR_AW-1:0]] <= wdata;
		end
		if (ctl.rd_en) begin
			raw_q <= mem_q[ctl.addr[CAR_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.addr[CAR_AW-1:0]] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= valid_q[ctl.addr[CAR_AW-1:0]];
			end
		end
	end

	assign rdata = rvld_q ? raw_q : RESET_REC;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the elevator group dispatcher
// A directed sequence and then random hall calls and ticks are sent with random
// gaps on the input and random stalls on the output, plus one long output stall.
// A mirror of the car group predicts every report beat, and each received beat
// is compared with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;
	import egsd_pkg::*;

	localparam int CARS          = NUM_CARS_DEF;
	localparam int FLOORS        = NUM_FLOORS_DEF;
	localparam int RANDOM_BEATS  = 210;
	localparam int LIMIT_CYCLES  = 300000;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER_IN = 80;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_REPORTED  = 10;

	// A direction code that no car can ever travel in; only idle cars match it.
	localparam logic [HEAD_W-1:0] DIR_NONE = 2'd3;

	// One report beat as the block presents it on m_tdata and m_tlast.
	typedef struct packed {
		logic [CAR_W-1:0]   car;
		logic [FLOOR_W-1:0] car_floor;
		logic [HEAD_W-1:0]  heading;
		logic               arrived;
		logic               assigned;
		logic               last;
	} car_report_t;

	// ------------------------------------------------------------------------
	// Mirror of the car group: it keeps its own copy of every car's pending
	// floors, position and heading, and queues the reports that each accepted
	// command must produce.
	// ------------------------------------------------------------------------
	class car_group_mirror;
		logic [FLOORS-1:0]  pending [CARS];
		logic [FLOOR_W-1:0] pos [CARS];
		logic [HEAD_W-1:0]  head [CARS];
		car_report_t        due_reports [$];
		int                 mismatches;

		function new();
			for (int i = 0; i < CARS; i++) begin
				pending[i] = '0;
				pos[i]     = '0;
				head[i]    = HEAD_IDLE;
			end
			mismatches = 0;
		endfunction

		function int lowest_set(logic [FLOORS-1:0] v);
			int idx;
			idx = FLOORS - 1;
			for (int i = FLOORS - 1; i >= 0; i--) begin
				if (v[i]) begin
					idx = i;
				end
			end
			return idx;
		endfunction

		function int highest_set(logic [FLOORS-1:0] v);
			int idx;
			idx = 0;
			for (int i = 0; i < FLOORS; i++) begin
				if (v[i]) begin
					idx = i;
				end
			end
			return idx;
		endfunction

		// One SCAN step of one car; returns 1 when the car served a floor.
		function bit scan_step(int c);
			logic [FLOORS-1:0] sel;
			int                target;
			if (pending[c] == '0) begin
				head[c] = HEAD_IDLE;
				return 1'b0;
			end
			if (head[c] == HEAD_IDLE) begin
				head[c] = (lowest_set(pending[c]) > int'(pos[c])) ? HEAD_UP : HEAD_DOWN;
			end
			if (head[c] == HEAD_UP) begin
				sel = pending[c] & ({FLOORS{1'b1}} << pos[c]);
				if (sel == '0) begin
					head[c] = HEAD_DOWN;
					return 1'b0;
				end
				target = lowest_set(sel);
			end else begin
				// Floors at or below the car; a shift by the full width gives zero, so the mask is all ones.
				sel = pending[c] & ~({FLOORS{1'b1}} << (int'(pos[c]) + 1));
				if (sel == '0) begin
					head[c] = HEAD_UP;
					return 1'b0;
				end
				target = highest_set(sel);
			end
			pos[c] = FLOOR_W'(target);
			pending[c][target] = 1'b0;
			return 1'b1;
		endfunction

		// Nearest qualifying car takes the hall call; ties go to the lowest index.
		function car_report_t assign_hall_call(logic [FLOOR_W-1:0] flr, logic [HEAD_W-1:0] dir);
			car_report_t rpt;
			bit          found;
			int          best;
			int          best_dist;
			int          span;
			found     = 1'b0;
			best      = 0;
			best_dist = 0;
			if (int'(flr) < FLOORS) begin
				for (int i = 0; i < CARS; i++) begin
					span = (pos[i] > flr) ? int'(pos[i]) - int'(flr) : int'(flr) - int'(pos[i]);
					if ((head[i] == HEAD_IDLE || head[i] == dir) && (!found || span < best_dist)) begin
						found     = 1'b1;
						best      = i;
						best_dist = span;
					end
				end
			end
			if (found) begin
				pending[best][flr] = 1'b1;
			end
			rpt.car       = found ? CAR_W'(best) : '0;
			rpt.car_floor = flr;
			rpt.heading   = '0;
			rpt.arrived   = 1'b0;
			rpt.assigned  = found;
			rpt.last      = 1'b1;
			return rpt;
		endfunction

		function void note_command(logic cmd, logic [FLOOR_W-1:0] flr, logic [HEAD_W-1:0] dir);
			car_report_t rpt;
			bit          moved;
			if (cmd == CMD_REQUEST) begin
				rpt         = assign_hall_call(flr, dir);
				due_reports = {due_reports, rpt};
			end else begin
				for (int i = 0; i < CARS; i++) begin
					moved         = scan_step(i);
					rpt.car       = CAR_W'(i);
					rpt.car_floor = pos[i];
					rpt.heading   = head[i];
					rpt.arrived   = moved;
					rpt.assigned  = 1'b0;
					rpt.last      = (i == CARS - 1);
					due_reports   = {due_reports, rpt};
				end
			end
		endfunction

		function void check_report(logic [15:0] data, logic last);
			car_report_t got;
			car_report_t want;
			got.car       = data[2:0];
			got.car_floor = data[8:3];
			got.heading   = data[10:9];
			got.arrived   = data[11];
			got.assigned  = data[12];
			got.last      = last;
			if (due_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED) begin
					$display("unexpected beat: car %0d floor %0d heading %0d arrived %0b assigned %0b last %0b",
						got.car, got.car_floor, got.heading, got.arrived, got.assigned, got.last);
				end
				return;
			end
			want = due_reports.pop_front();
			if (got.car !== want.car || got.car_floor !== want.car_floor
					|| got.heading !== want.heading || got.arrived !== want.arrived
					|| got.assigned !== want.assigned || got.last !== want.last
					|| data[15:13] !== 3'b000) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED) begin
					$display("mismatch: want car %0d floor %0d heading %0d arrived %0b assigned %0b last %0b",
						want.car, want.car_floor, want.heading, want.arrived, want.assigned,
						want.last);
					$display("          got  car %0d floor %0d heading %0d arrived %0b assigned %0b last %0b spare %0h",
						got.car, got.car_floor, got.heading, got.arrived, got.assigned, got.last,
						data[15:13]);
				end
			end
		endfunction

		function int outstanding();
			return due_reports.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // floor[5:0], direction[7:6]
	logic        s_tuser;   // command: 0 hall request, 1 tick
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // car[2:0], car_floor[8:3], heading[10:9], arrived[11],
	                        // assigned[12], zero[15:13]
	logic        m_tlast;

	car_group_mirror group;
	int              beats_in;
	int              cycle_count;
	int              send_burst;
	int              take_burst;

	elevator_group_scan_dispatch_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Gap lengths are mostly zero or short, now and then long; a burst counter
	// produces stretches with no gaps at all.
	function automatic int pick_gap(inout int burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if (r < 5) begin
			burst = $urandom_range(10, 30);
			return 0;
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(25, 70);
	endfunction

	// Offers one command beat after a random gap and returns at the edge that
	// accepts it. When the gap is zero, tvalid simply stays high.
	task automatic send_command(input logic cmd, input logic [FLOOR_W-1:0] flr,
			input logic [HEAD_W-1:0] dir);
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {dir, flr};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic hall_call(input logic [FLOOR_W-1:0] flr, input logic [HEAD_W-1:0] dir);
		send_command(CMD_REQUEST, flr, dir);
	endtask

	task automatic tick();
		send_command(CMD_TICK, '0, '0);
	endtask

	// Every accepted beat on either side is handled at the same edge, in one
	// process, from values sampled before that edge's updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				group.note_command(s_tuser, s_tdata[5:0], s_tdata[7:6]);
				beats_in++;
			end
			if (m_tvalid && m_tready) begin
				group.check_report(m_tdata, m_tlast);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Output side: random stalls with stretches of steady ready, and one long
	// hold-off once enough commands are in, so that the block backs up and
	// stops taking input while the sender keeps offering.
	initial begin
		int  stall;
		int  run;
		bit  held;
		held       = 1'b0;
		take_burst = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && beats_in >= HOLD_AFTER_IN) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap(take_burst);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		int               wait_cycles;
		int               r;
		logic [FLOOR_W-1:0] flr;
		logic [HEAD_W-1:0]  dir;

		group       = new();
		beats_in    = 0;
		cycle_count = 0;
		send_burst  = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		s_tdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A tick with nothing pending keeps every car idle.
		tick();
		// All cars idle at floor zero: the tie goes to car 0, at its own floor.
		hall_call(6'd0, HEAD_UP);
		// The call at the car's own floor is served in place.
		tick();
		// Car 0 now heads down, so an upward call goes to an idle car.
		hall_call(6'd63, HEAD_UP);
		hall_call(6'd40, HEAD_UP);
		hall_call(6'd20, HEAD_DOWN);
		// The code that names no heading matches idle cars only.
		hall_call(6'd10, DIR_NONE);
		// Car 0 finds nothing below and reverses without moving.
		tick();
		hall_call(6'd5, HEAD_DOWN);
		tick();
		// Every car now heads up: a downward call and an idle call find no car.
		hall_call(6'd1, HEAD_DOWN);
		hall_call(6'd2, HEAD_IDLE);
		hall_call(6'd63, HEAD_UP);
		tick();
		tick();
		hall_call(6'd0, HEAD_DOWN);
		tick();
		tick();
		tick();
		hall_call(6'd63, DIR_NONE);
		tick();
		tick();

		// Random part: hall calls with random content and ticks to drain them.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				tick();
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					flr = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
				end else begin
					flr = FLOOR_W'($urandom_range(0, FLOORS - 1));
				end
				r = $urandom_range(0, 99);
				if (r < 40) begin
					dir = HEAD_UP;
				end else if (r < 80) begin
					dir = HEAD_DOWN;
				end else if (r < 90) begin
					dir = HEAD_IDLE;
				end else begin
					dir = DIR_NONE;
				end
				hall_call(flr, dir);
			end
		end
		s_tvalid <= 1'b0;

		// Let every predicted beat arrive, then give the block time to show
		// anything extra.
		wait_cycles = 0;
		while (group.outstanding() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (group.outstanding() != 0) begin
			$display("%0d predicted beats never arrived", group.outstanding());
		end
		if (group.mismatches == 0 && group.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
